### design/stack_bytecode_execute_unit_defines.svh
// ----------------------------------------------------------------------------
// Stack bytecode execute unit assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef STACK_BYTECODE_EXECUTE_UNIT_DEFINES_SVH
`define STACK_BYTECODE_EXECUTE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SBE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SBE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/sbe_pkg.sv
// ----------------------------------------------------------------------------
// Stack bytecode execute unit package
// Opcodes, status codes, register indexes and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package sbe_pkg;

    localparam logic [7:0] OP_PUSH  = 8'd0;
    localparam logic [7:0] OP_POP   = 8'd1;
    localparam logic [7:0] OP_LOAD  = 8'd2;
    localparam logic [7:0] OP_PUT   = 8'd3;
    localparam logic [7:0] OP_ADD   = 8'd4;
    localparam logic [7:0] OP_SUB   = 8'd5;
    localparam logic [7:0] OP_MUL   = 8'd6;
    localparam logic [7:0] OP_DIV   = 8'd7;
    localparam logic [7:0] OP_EQ    = 8'd8;
    localparam logic [7:0] OP_NEQ   = 8'd9;
    localparam logic [7:0] OP_LT    = 8'd10;
    localparam logic [7:0] OP_LTE   = 8'd11;
    localparam logic [7:0] OP_GT    = 8'd12;
    localparam logic [7:0] OP_GTE   = 8'd13;
    localparam logic [7:0] OP_JMP   = 8'd14;
    localparam logic [7:0] OP_JMPZ  = 8'd15;
    localparam logic [7:0] OP_CALL  = 8'd16;
    localparam logic [7:0] OP_RET   = 8'd17;
    localparam logic [7:0] OP_SHOW  = 8'd18;
    localparam logic [7:0] OP_HALT  = 8'd19;

    localparam logic [2:0] ST_RUNNING    = 3'd0;
    localparam logic [2:0] ST_HALTED     = 3'd1;
    localparam logic [2:0] ST_INVALID    = 3'd2;
    localparam logic [2:0] ST_OVERFLOW   = 3'd3;
    localparam logic [2:0] ST_UNDERFLOW  = 3'd4;
    localparam logic [2:0] ST_DIV_ZERO   = 3'd5;
    localparam logic [2:0] ST_BAD_OPCODE = 3'd6;

    localparam logic [7:0] CFG_PROGRAM_LENGTH = 8'd0;
    localparam logic [7:0] CFG_START_ADDRESS  = 8'd1;

    localparam logic [16:0] PLEN_RESET = 17'h10000;

    typedef struct packed {
        logic take_item;
        logic flag_error;
        logic grab_b;
        logic read_next;
        logic grab_a;
        logic execute;
        logic div_begin;
        logic div_commit;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic stopped;
        logic pre_fail;
        logic need_value;
        logic need_local;
        logic is_binary;
        logic is_div;
        logic div_zero;
        logic div_done;
        logic out_free;
    } dp_status_t;

    function automatic logic [2:0] op_length(input logic [7:0] op);
        logic [2:0] len;
        case (op)
            OP_PUSH, OP_JMP, OP_JMPZ, OP_CALL: len = 3'd5;
            OP_LOAD, OP_PUT:                   len = 3'd2;
            default:                           len = 3'd1;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

### design/stack_bytecode_execute_unit.sv
// ----------------------------------------------------------------------------
// Stack bytecode execute unit
// Executes one stack-machine instruction per item and reports the new state.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Carries
//  item     item_valid/item_stall  action, operand_bytes
//  result   result_valid/result_stall  next_address, run_state, print_*, stack_depth
//  cfg      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// An instruction passes through check, execute and emit; an error, a halt or a
// stopped unit goes from check straight to emit. Store, jmpz and print first read
// the top operand, and two-operand ops read both operands in turn, as the operand
// stack memory has a single read port; divide also runs the bit-serial divider.
// Reset clears control state; locals read as zero until written.
// A stalled result holds the unit before it takes the next beat.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_bytecode_execute_unit
#(
    parameter int STACK_DEPTH      = 256,
    parameter int CALL_DEPTH       = 16,
    parameter int LOCALS_PER_FRAME = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic [7:0]         action,
    input  wire logic [31:0]        operand_bytes,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [15:0]             next_address,
    output logic [2:0]              run_state,
    output logic                    print_valid,
    output logic signed [31:0]      print_value,
    output logic [8:0]              stack_depth,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);

    sbe_pkg::ctrl_cmd_t  cmd;
    sbe_pkg::dp_status_t st;
    logic                cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    sbe_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .st         (st),
        .cmd        (cmd)
    );

    sbe_datapath
    #(
        .STACK_DEPTH      (STACK_DEPTH),
        .CALL_DEPTH       (CALL_DEPTH),
        .LOCALS_PER_FRAME (LOCALS_PER_FRAME)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .action        (action),
        .operand_bytes (operand_bytes),
        .cmd           (cmd),
        .st            (st),
        .result_stall  (result_stall),
        .result_valid  (result_valid),
        .next_address  (next_address),
        .run_state     (run_state),
        .print_valid   (print_valid),
        .print_value   (print_value),
        .stack_depth   (stack_depth)
    );

endmodule

`default_nettype wire

### design/sbe_ctrl.sv
// ----------------------------------------------------------------------------
// Stack bytecode execute unit controller
// Sequences check, operand reads, execute, divide and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module sbe_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire sbe_pkg::dp_status_t st,
    output sbe_pkg::ctrl_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_RDB   = 3'd2;
    localparam logic [2:0] S_RDA   = 3'd3;
    localparam logic [2:0] S_EXEC  = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (st.stopped)
                begin
                    state_next = S_EMIT;
                end
                else if (st.pre_fail)
                begin
                    cmd.flag_error = 1'b1;
                    state_next     = S_EMIT;
                end
                else if (st.need_value)
                begin
                    state_next = S_RDB;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_RDB:
            begin
                cmd.grab_b    = 1'b1;
                cmd.read_next = 1'b1;
                state_next    = st.is_binary ? S_RDA : S_EXEC;
            end
            S_RDA:
            begin
                cmd.grab_a = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (st.is_div && !st.div_zero)
                begin
                    cmd.div_begin = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.execute = 1'b1;
                    state_next  = S_EMIT;
                end
            end
            S_DIV:
            begin
                if (st.div_done)
                begin
                    cmd.div_commit = 1'b1;
                    state_next     = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### design/sbe_datapath.sv
// ----------------------------------------------------------------------------
// Stack bytecode execute unit datapath
// Operand stack, locals, call frames, ALU, serial divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbe_datapath
#(
    parameter int STACK_DEPTH      = 256,
    parameter int CALL_DEPTH       = 16,
    parameter int LOCALS_PER_FRAME = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write,
    input  wire logic [7:0]          cfg_index,
    input  wire logic [31:0]         cfg_data,
    input  wire logic [7:0]          action,
    input  wire logic [31:0]         operand_bytes,
    input  wire sbe_pkg::ctrl_cmd_t  cmd,
    output sbe_pkg::dp_status_t      st,
    input  wire logic                result_stall,
    output logic                     result_valid,
    output logic [15:0]              next_address,
    output logic [2:0]               run_state,
    output logic                     print_valid,
    output logic signed [31:0]       print_value,
    output logic [8:0]               stack_depth
);

    localparam int STK_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CALL_W  = $clog2(CALL_DEPTH);
    localparam int LOC_W   = (LOCALS_PER_FRAME > 1) ? $clog2(LOCALS_PER_FRAME) : 1;
    localparam int LDEPTH  = CALL_DEPTH * LOCALS_PER_FRAME;
    localparam int LADDR_W = $clog2(LDEPTH);

    logic [7:0]       op_reg;
    logic [31:0]      opnd_reg;
    logic [15:0]      ip_reg, ip_next;
    logic [16:0]      plen_reg, plen_next;
    logic [STK_W:0]   top_reg, top_next;
    logic [CALL_W:0]  level_reg, level_next;
    logic [2:0]       status_reg, status_next;
    logic [31:0]      pv_reg, pv_next;
    logic             pvalid_reg, pvalid_next;
    logic [31:0]      b_reg, a_reg;
    logic [31:0]      stack_rd_reg, local_rd_reg;
    logic [15:0]      ret_rd_reg;
    logic [STK_W:0]   saved_rd_reg;

    logic [31:0]      stack_mem [STACK_DEPTH];
    logic [31:0]      local_mem [LDEPTH];
    logic [LDEPTH-1:0] local_valid_reg;
    logic [15:0]      ret_mem   [CALL_DEPTH];
    logic [STK_W:0]   saved_mem [CALL_DEPTH];

    logic [31:0]      rem_reg, quo_reg;
    logic [4:0]       div_cnt_reg;
    logic             div_busy_reg;
    logic [32:0]      rem_shift;
    logic [32:0]      rem_diff;

    logic             res_valid_reg;
    logic [15:0]      res_addr_reg;
    logic [2:0]       res_state_reg;
    logic             res_pvalid_reg;
    logic [31:0]      res_pv_reg;
    logic [8:0]       res_depth_reg;

    logic [17:0]      ip_end;
    logic [15:0]      fall_ip;
    logic             target_ok;
    logic             idx_bad;
    logic             top_full, top_empty, top_lt2;
    logic             level_full, level_base;
    logic             op_binary;
    logic [2:0]       pre_err;
    logic [CALL_W-1:0] lvl_idx;
    logic [LADDR_W-1:0] local_addr;
    logic [STK_W:0]   top_m1, top_m2;
    logic [STK_W-1:0] stack_raddr;
    logic             stack_we;
    logic [STK_W-1:0] stack_waddr;
    logic [31:0]      stack_wdata;
    logic             local_we;
    logic             frame_we;
    logic [31:0]      alu_r;
    logic [31:0]      depth_wide;

    assign ip_end     = {2'b00, ip_reg} + 18'(sbe_pkg::op_length(op_reg));
    assign fall_ip    = ip_end[15:0];
    assign target_ok  = (opnd_reg < {15'd0, plen_reg}) && (opnd_reg[31:16] == 16'd0);
    assign idx_bad    = ({1'b0, opnd_reg[7:0]} >= 9'(LOCALS_PER_FRAME));
    assign top_full   = (top_reg >= (STK_W+1)'(STACK_DEPTH));
    assign top_empty  = (top_reg == '0);
    assign top_lt2    = (top_reg < (STK_W+1)'(2));
    assign level_full = (level_reg >= (CALL_W+1)'(CALL_DEPTH));
    assign level_base = (level_reg <= (CALL_W+1)'(1));
    assign op_binary  = (op_reg >= sbe_pkg::OP_ADD) && (op_reg <= sbe_pkg::OP_GTE);
    assign top_m1     = top_reg - (STK_W+1)'(1);
    assign top_m2     = top_reg - (STK_W+1)'(2);

    logic [CALL_W:0] level_m1;
    assign level_m1 = level_reg - (CALL_W+1)'(1);
    assign lvl_idx  = level_m1[CALL_W-1:0];
    assign local_addr = LADDR_W'(32'(lvl_idx) * LOCALS_PER_FRAME
                                 + 32'(opnd_reg[LOC_W-1:0]));

    always_comb
    begin
        pre_err = sbe_pkg::ST_RUNNING;
        if ({1'b0, ip_reg} >= plen_reg)
        begin
            pre_err = sbe_pkg::ST_INVALID;
        end
        else if (op_reg > sbe_pkg::OP_HALT)
        begin
            pre_err = sbe_pkg::ST_BAD_OPCODE;
        end
        else if (ip_end > {1'b0, plen_reg})
        begin
            pre_err = sbe_pkg::ST_INVALID;
        end
        else
        begin
            case (op_reg) inside
                sbe_pkg::OP_PUSH:
                    if (top_full) pre_err = sbe_pkg::ST_OVERFLOW;
                sbe_pkg::OP_POP, sbe_pkg::OP_SHOW, sbe_pkg::OP_JMPZ:
                    if (top_empty) pre_err = sbe_pkg::ST_UNDERFLOW;
                sbe_pkg::OP_LOAD:
                    if (idx_bad) pre_err = sbe_pkg::ST_INVALID;
                    else if (top_full) pre_err = sbe_pkg::ST_OVERFLOW;
                sbe_pkg::OP_PUT:
                    if (idx_bad) pre_err = sbe_pkg::ST_INVALID;
                    else if (top_empty) pre_err = sbe_pkg::ST_UNDERFLOW;
                [sbe_pkg::OP_ADD:sbe_pkg::OP_GTE]:
                    if (top_lt2) pre_err = sbe_pkg::ST_UNDERFLOW;
                sbe_pkg::OP_JMP:
                    if (!target_ok) pre_err = sbe_pkg::ST_INVALID;
                sbe_pkg::OP_CALL:
                    if (level_full) pre_err = sbe_pkg::ST_OVERFLOW;
                    else if (!target_ok) pre_err = sbe_pkg::ST_INVALID;
                sbe_pkg::OP_RET:
                    if (level_base) pre_err = sbe_pkg::ST_UNDERFLOW;
                sbe_pkg::OP_HALT:
                    pre_err = sbe_pkg::ST_HALTED;
                default:
                    pre_err = sbe_pkg::ST_RUNNING;
            endcase
        end
    end

    always_comb
    begin
        case (op_reg)
            sbe_pkg::OP_ADD: alu_r = a_reg + b_reg;
            sbe_pkg::OP_SUB: alu_r = a_reg - b_reg;
            sbe_pkg::OP_MUL: alu_r = a_reg * b_reg;
            sbe_pkg::OP_EQ:  alu_r = {31'd0, a_reg == b_reg};
            sbe_pkg::OP_NEQ: alu_r = {31'd0, a_reg != b_reg};
            sbe_pkg::OP_LT:  alu_r = {31'd0, a_reg < b_reg};
            sbe_pkg::OP_LTE: alu_r = {31'd0, a_reg <= b_reg};
            sbe_pkg::OP_GT:  alu_r = {31'd0, a_reg > b_reg};
            sbe_pkg::OP_GTE: alu_r = {31'd0, a_reg >= b_reg};
            default:         alu_r = 32'd0;
        endcase
    end

    always_comb
    begin
        st.stopped    = (status_reg != sbe_pkg::ST_RUNNING);
        st.pre_fail   = (pre_err != sbe_pkg::ST_RUNNING);
        st.need_value = op_binary || (op_reg == sbe_pkg::OP_PUT)
                        || (op_reg == sbe_pkg::OP_JMPZ) || (op_reg == sbe_pkg::OP_SHOW);
        st.need_local = (op_reg == sbe_pkg::OP_LOAD);
        st.is_binary  = op_binary;
        st.is_div     = (op_reg == sbe_pkg::OP_DIV);
        st.div_zero   = (b_reg == 32'd0);
        st.div_done   = !div_busy_reg;
        st.out_free   = !res_valid_reg || !result_stall;
    end

    always_comb
    begin
        ip_next     = ip_reg;
        plen_next   = plen_reg;
        top_next    = top_reg;
        level_next  = level_reg;
        status_next = status_reg;
        pv_next     = pv_reg;
        pvalid_next = pvalid_reg;
        stack_we    = 1'b0;
        stack_waddr = top_reg[STK_W-1:0];
        stack_wdata = opnd_reg;
        local_we    = 1'b0;
        frame_we    = 1'b0;

        if (cfg_write && (cfg_index == sbe_pkg::CFG_PROGRAM_LENGTH))
        begin
            plen_next = cfg_data[16:0];
        end
        if (cfg_write && (cfg_index == sbe_pkg::CFG_START_ADDRESS))
        begin
            ip_next = cfg_data[15:0];
        end
        if (cmd.take_item)
        begin
            pv_next     = 32'd0;
            pvalid_next = 1'b0;
        end
        if (cmd.flag_error)
        begin
            status_next = pre_err;
        end
        if (cmd.execute)
        begin
            case (op_reg) inside
                sbe_pkg::OP_PUSH:
                begin
                    stack_we = 1'b1;
                    top_next = top_reg + (STK_W+1)'(1);
                    ip_next  = fall_ip;
                end
                sbe_pkg::OP_POP:
                begin
                    top_next = top_m1;
                    ip_next  = fall_ip;
                end
                sbe_pkg::OP_LOAD:
                begin
                    stack_we    = 1'b1;
                    stack_wdata = local_rd_reg;
                    top_next    = top_reg + (STK_W+1)'(1);
                    ip_next     = fall_ip;
                end
                sbe_pkg::OP_PUT:
                begin
                    local_we = 1'b1;
                    top_next = top_m1;
                    ip_next  = fall_ip;
                end
                [sbe_pkg::OP_ADD:sbe_pkg::OP_GTE]:
                begin
                    if (op_reg == sbe_pkg::OP_DIV)
                    begin
                        top_next    = top_m2;
                        status_next = sbe_pkg::ST_DIV_ZERO;
                    end
                    else
                    begin
                        stack_we    = 1'b1;
                        stack_waddr = top_m2[STK_W-1:0];
                        stack_wdata = alu_r;
                        top_next    = top_m1;
                        ip_next     = fall_ip;
                    end
                end
                sbe_pkg::OP_JMP:
                begin
                    ip_next = opnd_reg[15:0];
                end
                sbe_pkg::OP_JMPZ:
                begin
                    top_next = top_m1;
                    if (b_reg != 32'd0)
                    begin
                        ip_next = fall_ip;
                    end
                    else if (target_ok)
                    begin
                        ip_next = opnd_reg[15:0];
                    end
                    else
                    begin
                        status_next = sbe_pkg::ST_INVALID;
                    end
                end
                sbe_pkg::OP_CALL:
                begin
                    frame_we   = 1'b1;
                    level_next = level_reg + (CALL_W+1)'(1);
                    ip_next    = opnd_reg[15:0];
                end
                sbe_pkg::OP_RET:
                begin
                    level_next = level_m1;
                    top_next   = saved_rd_reg;
                    ip_next    = ret_rd_reg;
                end
                sbe_pkg::OP_SHOW:
                begin
                    pv_next     = b_reg;
                    pvalid_next = 1'b1;
                    top_next    = top_m1;
                    ip_next     = fall_ip;
                end
                default:
                begin
                    ip_next = ip_reg;
                end
            endcase
        end
        if (cmd.div_commit)
        begin
            stack_we    = 1'b1;
            stack_waddr = top_m2[STK_W-1:0];
            stack_wdata = quo_reg;
            top_next    = top_m1;
            ip_next     = fall_ip;
        end
    end

    assign stack_raddr = cmd.read_next ? top_m2[STK_W-1:0] : top_m1[STK_W-1:0];

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        stack_rd_reg <= stack_mem[stack_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (local_we)
        begin
            local_mem[local_addr] <= b_reg;
        end
        local_rd_reg <= local_valid_reg[local_addr] ? local_mem[local_addr] : 32'd0;
    end

    always_ff @(posedge clk)
    begin
        if (frame_we)
        begin
            ret_mem[level_reg[CALL_W-1:0]]   <= fall_ip;
            saved_mem[level_reg[CALL_W-1:0]] <= top_reg;
        end
        ret_rd_reg   <= ret_mem[lvl_idx];
        saved_rd_reg <= saved_mem[lvl_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            op_reg   <= action;
            opnd_reg <= operand_bytes;
        end
        if (cmd.grab_b)
        begin
            b_reg <= stack_rd_reg;
        end
        if (cmd.grab_a)
        begin
            a_reg <= stack_rd_reg;
        end
    end

    assign rem_shift = {rem_reg, quo_reg[31]};
    assign rem_diff  = rem_shift - {1'b0, b_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_begin)
        begin
            rem_reg <= 32'd0;
            quo_reg <= a_reg;
        end
        else if (div_busy_reg)
        begin
            if (!rem_diff[32])
            begin
                rem_reg <= rem_diff[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[31:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= 5'd0;
        end
        else if (cmd.div_begin)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= 5'd0;
        end
        else if (div_busy_reg)
        begin
            div_cnt_reg <= div_cnt_reg + 5'd1;
            if (div_cnt_reg == 5'd31)
            begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_reg          <= 16'd0;
            plen_reg        <= sbe_pkg::PLEN_RESET;
            top_reg         <= '0;
            level_reg       <= (CALL_W+1)'(1);
            status_reg      <= sbe_pkg::ST_RUNNING;
            pv_reg          <= 32'd0;
            pvalid_reg      <= 1'b0;
            local_valid_reg <= '0;
        end
        else
        begin
            ip_reg     <= ip_next;
            plen_reg   <= plen_next;
            top_reg    <= top_next;
            level_reg  <= level_next;
            status_reg <= status_next;
            pv_reg     <= pv_next;
            pvalid_reg <= pvalid_next;
            if (local_we)
            begin
                local_valid_reg[local_addr] <= 1'b1;
            end
        end
    end

    assign depth_wide = 32'(top_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_addr_reg   <= ip_reg;
            res_state_reg  <= status_reg;
            res_pvalid_reg <= pvalid_reg;
            res_pv_reg     <= pv_reg;
            res_depth_reg  <= depth_wide[8:0];
        end
    end

    assign result_valid = res_valid_reg;
    assign next_address = res_addr_reg;
    assign run_state    = res_state_reg;
    assign print_valid  = res_pvalid_reg;
    assign print_value  = res_pv_reg;
    assign stack_depth  = res_depth_reg;

endmodule

`default_nettype wire

### design/sbe_checker.sv
// ----------------------------------------------------------------------------
// Stack bytecode execute unit checker
// Port-level properties of the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stack_bytecode_execute_unit_defines.svh"

module sbe_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               item_valid,
    input wire logic               item_stall,
    input wire logic               result_valid,
    input wire logic               result_stall,
    input wire logic [15:0]        next_address,
    input wire logic [2:0]         run_state,
    input wire logic               print_valid,
    input wire logic signed [31:0] print_value,
    input wire logic [8:0]         stack_depth
);

    `SBE_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(next_address) && $stable(run_state) && $stable(print_value) && $stable(stack_depth), "stalled result beat changed")
    `SBE_ASSERT_IMPL(a_print_running, result_valid && print_valid, run_state == sbe_pkg::ST_RUNNING, "print reported with a stopped status")
    `SBE_ASSERT_IMPL(a_print_zero, result_valid && !print_valid, print_value == 32'sd0, "print value not zero without print")
    `SBE_ASSERT_NEXT(a_one_at_a_time, item_valid && !item_stall, item_stall, "second item taken while one is in flight")

endmodule

bind stack_bytecode_execute_unit sbe_checker u_sbe_checker (.*);

`default_nettype wire
